// File: design/atcfp_pkg.sv
// Shared types and constants for the AT command frame parser.
package atcfp_pkg;

  localparam int MAX_PAYLOAD = 9;
  localparam int MAX_DIGIT   = 9;

  localparam int CMD_W  = 3;
  localparam int FREQ_W = 31;
  localparam int ACC_W  = 30;   // holds the saturated magnitude 1e9
  localparam int MUL_W  = ACC_W + 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_FREQ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START_ANA = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TERMINATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START_DIG = 3'd4;

  localparam logic [MUL_W-1:0] POS_LIMIT = 34'd999999999;
  localparam logic [ACC_W-1:0] POS_SAT   = 30'd999999999;
  localparam logic [ACC_W-1:0] NEG_SAT   = 30'd99999999;
  localparam logic [ACC_W-1:0] OVF_VAL   = 30'd1000000000;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // keyword tables, padded to a power of two; pad entries are never compared
  localparam logic [7:0] KW_MON   [4] = '{CH_M, CH_O, CH_N, 8'h00};
  localparam logic [7:0] KW_MOFF  [4] = '{CH_M, CH_O, CH_UP_F, CH_UP_F};
  localparam logic [7:0] KW_MRON  [4] = '{CH_M, CH_R, CH_O, CH_N};
  localparam logic [7:0] KW_MROFF [8] = '{CH_M, CH_R, CH_O, CH_UP_F, CH_UP_F,
                                          8'h00, 8'h00, 8'h00};

  typedef enum logic [2:0] {
    PH_WAIT_A = 3'd0,
    PH_WAIT_T = 3'd1,
    PH_LEN    = 3'd2,
    PH_TYPE   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  // number scan: skipping blanks (sign allowed), in sign/digits, finished
  typedef enum logic [1:0] {
    NP_BLANK = 2'd0,
    NP_DIGIT = 2'd1,
    NP_DONE  = 2'd2
  } numph_t;

endpackage

// File: design/at_command_frame_parser.sv
// AT command frame parser: header hunt, length/type decode, per-byte payload parse.
//
//  channel | ports                                         | dir | note
//  --------+-----------------------------------------------+-----+---------------------
//  in      | in_valid, in_ready, in_rx_byte                | in  | one byte per item
//  out     | out_valid, out_ready, out_command,            | out | one item at frame end
//          | out_frequency, out_frequency_parsed           |     |
//
// One byte is taken every cycle while in_ready is high; each byte updates the frame
// state, the running decimal scan and the keyword match flags as it is taken.
// The result of a frame is registered and shows in the cycle after its last byte.
// in_ready drops only when the frame's last byte is due and the result register
// still holds an item that is not taken; all other bytes flow during a stall.
// rst_n (synchronous) returns the block to hunting for 'A' and clears the
// remembered frequency. No clearing pass is needed.
module at_command_frame_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [atcfp_pkg::CMD_W-1:0]          out_command,
  output logic signed [atcfp_pkg::FREQ_W-1:0] out_frequency,
  output logic                                 out_frequency_parsed
);
  import atcfp_pkg::*;

  phase_t                    phase_r, phase_nxt;
  logic [3:0]                len_r, len_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  numph_t                    nump_r, nump_nxt, nump_upd;
  logic                      neg_r, neg_nxt, neg_upd;
  logic                      any_r, any_nxt, any_upd;
  logic [ACC_W-1:0]          acc_r, acc_nxt, acc_upd;
  logic                      mon_r, moff_r, mron_r, mroff_r;
  logic                      mon_nxt, moff_nxt, mron_nxt, mroff_nxt;
  logic                      mon_upd, moff_upd, mron_upd, mroff_upd;
  logic signed [FREQ_W-1:0]  last_freq_r, last_freq_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]          out_cmd_r, out_cmd_nxt;
  logic signed [FREQ_W-1:0]  out_freq_r, out_freq_nxt;
  logic                      out_parsed_r, out_parsed_nxt;

  logic                      last_byte;
  logic                      accept;
  logic [7:0]                b;
  logic                      is_blank, is_sign, is_digit;
  logic [3:0]                digit;
  logic [7:0]                len_byte;
  logic [MUL_W-1:0]          acc_ext, acc_mul;
  logic [ACC_W-1:0]          mag;
  logic signed [FREQ_W-1:0]  num_val;
  logic [CMD_W-1:0]          cmd;
  logic signed [FREQ_W-1:0]  freq;
  logic                      parsed;

  assign b         = in_rx_byte;
  assign last_byte = (phase_r == PH_DATA) && ((cnt_r + 4'd1) == len_r);
  assign in_ready  = !out_valid_r || out_ready || !last_byte;
  assign accept    = in_valid && in_ready;

  assign is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  assign len_byte = b - CH_ZERO;

  // acc * 10 + digit
  assign acc_ext = {4'b0, acc_r};
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{(MUL_W-4){1'b0}}, digit};

  // running decimal scan, one payload byte per cycle while in_ready is high
  always_comb begin
    nump_upd = nump_r;
    neg_upd  = neg_r;
    any_upd  = any_r;
    acc_upd  = acc_r;
    case (nump_r)
      NP_BLANK: begin
        if (is_sign) begin
          neg_upd  = (b == CH_MINUS);
          nump_upd = NP_DIGIT;
        end else if (is_digit) begin
          acc_upd  = (acc_mul > POS_LIMIT) ? OVF_VAL : acc_mul[ACC_W-1:0];
          any_upd  = 1'b1;
          nump_upd = NP_DIGIT;
        end else if (!is_blank) begin
          nump_upd = NP_DONE;
        end
      end
      NP_DIGIT: begin
        if (is_digit) begin
          acc_upd = (acc_mul > POS_LIMIT) ? OVF_VAL : acc_mul[ACC_W-1:0];
          any_upd = 1'b1;
        end else begin
          nump_upd = NP_DONE;
        end
      end
      default: nump_upd = NP_DONE;
    endcase
  end

  // keyword prefixes: a flag clears on the first mismatch inside its length
  assign mon_upd   = mon_r   && ((cnt_r >= 4'd3) || (b == KW_MON[cnt_r[1:0]]));
  assign moff_upd  = moff_r  && ((cnt_r >= 4'd4) || (b == KW_MOFF[cnt_r[1:0]]));
  assign mron_upd  = mron_r  && ((cnt_r >= 4'd4) || (b == KW_MRON[cnt_r[1:0]]));
  assign mroff_upd = mroff_r && ((cnt_r >= 4'd5) || (b == KW_MROFF[cnt_r[2:0]]));

  // frame result, valid when the current byte is the last one
  always_comb begin
    if (neg_upd) mag = (acc_upd > NEG_SAT) ? NEG_SAT : acc_upd;
    else         mag = (acc_upd > POS_SAT) ? POS_SAT : acc_upd;
    num_val = neg_upd ? (FREQ_W'(0) - {1'b0, mag}) : {1'b0, mag};

    cmd    = CMD_NONE;
    freq   = '0;
    parsed = 1'b0;
    case (type_r)
      CH_LO_F: begin
        cmd    = CMD_SET_FREQ;
        parsed = any_upd;
        freq   = any_upd ? num_val : last_freq_r;
      end
      CH_UP_F: begin
        if (mon_upd && (len_r >= 4'd3))       cmd = CMD_START_ANA;
        else if (moff_upd && (len_r >= 4'd4)) cmd = CMD_TERMINATE;
      end
      CH_UP_D: begin
        if (mron_upd && (len_r >= 4'd4))       cmd = CMD_START_DIG;
        else if (mroff_upd && (len_r >= 4'd5)) cmd = CMD_TERMINATE;
      end
      default: cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    cnt_nxt        = cnt_r;
    nump_nxt       = nump_r;
    neg_nxt        = neg_r;
    any_nxt        = any_r;
    acc_nxt        = acc_r;
    mon_nxt        = mon_r;
    moff_nxt       = moff_r;
    mron_nxt       = mron_r;
    mroff_nxt      = mroff_r;
    last_freq_nxt  = last_freq_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cmd_nxt    = out_cmd_r;
    out_freq_nxt   = out_freq_r;
    out_parsed_nxt = out_parsed_r;

    if (accept) begin
      case (phase_r)
        PH_WAIT_T: begin
          if (b == CH_T) phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if ((len_byte >= 8'd1) && (len_byte <= 8'(MAX_DIGIT)) &&
              (len_byte <= 8'(MAX_PAYLOAD))) begin
            len_nxt   = len_byte[3:0];
            cnt_nxt   = '0;
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_WAIT_A;
          end
        end
        PH_TYPE: begin
          type_nxt  = b;
          nump_nxt  = NP_BLANK;
          neg_nxt   = 1'b0;
          any_nxt   = 1'b0;
          acc_nxt   = '0;
          mon_nxt   = 1'b1;
          moff_nxt  = 1'b1;
          mron_nxt  = 1'b1;
          mroff_nxt = 1'b1;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          cnt_nxt   = cnt_r + 4'd1;
          nump_nxt  = nump_upd;
          neg_nxt   = neg_upd;
          any_nxt   = any_upd;
          acc_nxt   = acc_upd;
          mon_nxt   = mon_upd;
          moff_nxt  = moff_upd;
          mron_nxt  = mron_upd;
          mroff_nxt = mroff_upd;
          if (last_byte) begin
            cnt_nxt        = '0;
            phase_nxt      = PH_WAIT_A;
            out_valid_nxt  = 1'b1;
            out_cmd_nxt    = cmd;
            out_freq_nxt   = freq;
            out_parsed_nxt = parsed;
            if (parsed) last_freq_nxt = num_val;
          end
        end
        default: begin
          phase_nxt = (b == CH_A) ? PH_WAIT_T : PH_WAIT_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_A;
      len_r       <= '0;
      type_r      <= '0;
      cnt_r       <= '0;
      nump_r      <= NP_BLANK;
      last_freq_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      type_r      <= type_nxt;
      cnt_r       <= cnt_nxt;
      nump_r      <= nump_nxt;
      last_freq_r <= last_freq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    any_r        <= any_nxt;
    acc_r        <= acc_nxt;
    mon_r        <= mon_nxt;
    moff_r       <= moff_nxt;
    mron_r       <= mron_nxt;
    mroff_r      <= mroff_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_freq_r   <= out_freq_nxt;
    out_parsed_r <= out_parsed_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_command          = out_cmd_r;
  assign out_frequency        = out_freq_r;
  assign out_frequency_parsed = out_parsed_r;

endmodule

// File: design/atcfp_checker.sv
// Port-level checks for the AT command frame parser, bound to the top level.
module atcfp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [7:0]                           in_rx_byte,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [atcfp_pkg::CMD_W-1:0]          out_command,
  input logic signed [atcfp_pkg::FREQ_W-1:0]  out_frequency,
  input logic                                 out_frequency_parsed
);
  import atcfp_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
      $stable(out_frequency) && $stable(out_frequency_parsed))
    else $error("result changed while stalled");

  // a new result only follows an accepted byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  a_parsed_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frequency_parsed |-> out_command == CMD_SET_FREQ)
    else $error("parsed flag on a non-frequency item");

  a_freq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command != CMD_SET_FREQ) |-> out_frequency == '0)
    else $error("frequency set on a non-frequency item");

  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frequency <= 31'sd999999999) &&
      (out_frequency >= -31'sd99999999))
    else $error("frequency out of range");

endmodule

bind at_command_frame_parser atcfp_checker u_atcfp_checker (.*);
